>>> sv/ntci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntci_pkg
// Shared widths, types and the fixed thermistor table of the interpolator.
// ----------------------------------------------------------------------------
package ntci_pkg;

  localparam int TABLE_ROWS = 19;
  localparam int IDX_W      = 5;
  localparam int VOLT_W     = 16;
  localparam int TEMP_W     = 19;
  localparam int RES_W      = 17;
  localparam int NUM_W      = 11;
  localparam int DT_W       = 15;
  localparam int DR_W       = 16;
  localparam int PROD_W     = 27;
  localparam int Q_W        = 16;

  localparam logic [IDX_W-1:0] FIRST_IDX = '0;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ROWS - 1);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_COLD = 2'd1,
    ST_HOT  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [RES_W-1:0]         res;
    logic [VOLT_W-1:0]        volt;
  } row_t;

  typedef struct packed {
    logic              den_ok;
    logic              dt_neg;
    logic [DT_W-1:0]   dt_mag;
    logic              dr_neg;
    logic [DR_W-1:0]   dr_mag;
    logic [NUM_W-1:0]  den;
  } seg_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  idx;
    logic [NUM_W-1:0]  num;
  } item_t;

  function automatic row_t mk_row(input int t, input int r, input int v);
    row_t row;
    row.temp = TEMP_W'(t);
    row.res  = RES_W'(r);
    row.volt = VOLT_W'(v);
    return row;
  endfunction

  function automatic row_t row_at(input logic [IDX_W-1:0] idx);
    row_t row;
    case (idx)
      5'd0:    row = mk_row(-20000, 87430, 22628);
      5'd1:    row = mk_row(-10000, 51820, 21476);
      5'd2:    row = mk_row(     0, 31770, 20131);
      5'd3:    row = mk_row(  5000, 24940, 19398);
      5'd4:    row = mk_row( 10000, 19680, 18662);
      5'd5:    row = mk_row( 15000, 15620, 17946);
      5'd6:    row = mk_row( 20000, 12470, 17266);
      5'd7:    row = mk_row( 25000, 10000, 16633);
      5'd8:    row = mk_row( 30000,  8064, 16060);
      5'd9:    row = mk_row( 35000,  6538, 15548);
      5'd10:   row = mk_row( 40000,  5327, 15099);
      5'd11:   row = mk_row( 50000,  3592, 14374);
      5'd12:   row = mk_row( 60000,  2472, 13847);
      5'd13:   row = mk_row( 70000,  1735, 13471);
      5'd14:   row = mk_row( 80000,  1243, 13205);
      5'd15:   row = mk_row( 90000,   908, 13017);
      5'd16:   row = mk_row(100000,   674, 12882);
      5'd17:   row = mk_row(120000,   384, 12710);
      5'd18:   row = mk_row(150000,   177, 12584);
      default: row = mk_row(0, 0, 0);
    endcase
    return row;
  endfunction

  // segment between row idx-1 (upper voltage) and row idx
  function automatic seg_t seg_at(input logic [IDX_W-1:0] idx);
    row_t lo;
    row_t hi;
    int   dt;
    int   dr;
    int   dv;
    seg_t seg;
    lo = row_at(idx);
    hi = row_at(idx - 1'b1);
    dt = int'(hi.temp) - int'(lo.temp);
    dr = int'(hi.res) - int'(lo.res);
    dv = int'(hi.volt) - int'(lo.volt);
    seg.den_ok = (dv > 0);
    seg.dt_neg = (dt < 0);
    seg.dt_mag = DT_W'((dt < 0) ? -dt : dt);
    seg.dr_neg = (dr < 0);
    seg.dr_mag = DR_W'((dr < 0) ? -dr : dr);
    seg.den    = NUM_W'(dv);
    return seg;
  endfunction

endpackage

>>> sv/ntci_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntci_front
// Accepts a sample, searches the table in parallel and registers the row
// index, the offset from that row and the range status.
// ----------------------------------------------------------------------------
module ntci_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ntci_pkg::VOLT_W-1:0] in_sense_voltage,
  output logic                        busy,
  output logic                        push,
  output ntci_pkg::item_t             push_item,
  input  logic                        full
);

  logic                              valid_r;
  logic                              valid_nxt;
  ntci_pkg::item_t                   item_r;
  ntci_pkg::item_t                   item_nxt;
  logic [ntci_pkg::TABLE_ROWS-1:0]   at_or_below;
  logic [ntci_pkg::IDX_W-1:0]        idx_c;
  logic [ntci_pkg::VOLT_W-1:0]       diff_c;
  logic                              accept;

  assign busy   = valid_r && full;
  assign accept = start && !busy;
  assign push   = valid_r;
  assign push_item = item_r;

  always_comb begin
    ntci_pkg::row_t row_i;
    ntci_pkg::row_t row_sel;
    ntci_pkg::row_t row_first;

    for (int i = 0; i < ntci_pkg::TABLE_ROWS; i++) begin
      row_i          = ntci_pkg::row_at(ntci_pkg::IDX_W'(i));
      at_or_below[i] = (row_i.volt <= in_sense_voltage);
    end
    idx_c = ntci_pkg::LAST_IDX;
    for (int i = ntci_pkg::TABLE_ROWS - 1; i >= 0; i--) begin
      if (at_or_below[i]) begin
        idx_c = ntci_pkg::IDX_W'(i);
      end
    end
    row_sel   = ntci_pkg::row_at(idx_c);
    row_first = ntci_pkg::row_at(ntci_pkg::FIRST_IDX);
    diff_c    = in_sense_voltage - row_sel.volt;

    item_nxt.idx = idx_c;
    item_nxt.num = diff_c[ntci_pkg::NUM_W-1:0];
    if (in_sense_voltage > row_first.volt) begin
      item_nxt.status = ntci_pkg::ST_COLD;
    end else if (!at_or_below[ntci_pkg::TABLE_ROWS-1]) begin
      item_nxt.status = ntci_pkg::ST_HOT;
    end else begin
      item_nxt.status = ntci_pkg::ST_OK;
    end

    if (accept) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !full) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> sv/ntci_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntci_fifo
// Short queue between the classifying front and the arithmetic back; the
// back drains one entry every cycle it holds one.
// ----------------------------------------------------------------------------
module ntci_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ntci_pkg::item_t push_item,
  output logic            full,
  output logic            q_valid,
  output ntci_pkg::item_t q_item
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ntci_pkg::item_t    mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> sv/ntci_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntci_back
// Segment lookup and multiply, a pipelined restoring divider with one
// quotient bit per stage for temperature and resistance, and the result
// register.
// ----------------------------------------------------------------------------
module ntci_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  ntci_pkg::item_t                    q_item,
  output logic                               out_strobe,
  output logic signed [ntci_pkg::TEMP_W-1:0] out_temperature,
  output logic [ntci_pkg::RES_W-1:0]         out_resistance,
  output logic [1:0]                         out_status
);

  localparam int NSTG = ntci_pkg::Q_W + 1;

  typedef struct packed {
    logic                               valid;
    ntci_pkg::status_t                  status;
    logic signed [ntci_pkg::TEMP_W-1:0] base_t;
    logic [ntci_pkg::RES_W-1:0]         base_r;
    logic                               t_neg;
    logic                               r_neg;
    logic [ntci_pkg::NUM_W-1:0]         den;
    logic [ntci_pkg::PROD_W-1:0]        rem_t;
    logic [ntci_pkg::PROD_W-1:0]        rem_r;
    logic [ntci_pkg::Q_W-1:0]           q_t;
    logic [ntci_pkg::Q_W-1:0]           q_r;
  } dstage_t;

  dstage_t                            st_r   [NSTG];
  dstage_t                            st_nxt [NSTG];
  logic                               out_strobe_r;
  logic signed [ntci_pkg::TEMP_W-1:0] out_temperature_r;
  logic signed [ntci_pkg::TEMP_W-1:0] out_temperature_nxt;
  logic [ntci_pkg::RES_W-1:0]         out_resistance_r;
  logic [ntci_pkg::RES_W-1:0]         out_resistance_nxt;
  logic [1:0]                         out_status_r;

  always_comb begin
    ntci_pkg::row_t              cur;
    ntci_pkg::row_t              row_first;
    ntci_pkg::row_t              row_last;
    ntci_pkg::seg_t              seg;
    logic                        interp;
    logic [ntci_pkg::PROD_W-1:0] dsh;
    logic                        bit_t;
    logic                        bit_r;
    logic signed [ntci_pkg::TEMP_W-1:0] qt_ext;
    logic [ntci_pkg::RES_W-1:0]  qr_ext;

    // segment lookup and products
    cur       = ntci_pkg::row_at(q_item.idx);
    row_first = ntci_pkg::row_at(ntci_pkg::FIRST_IDX);
    row_last  = ntci_pkg::row_at(ntci_pkg::LAST_IDX);
    seg       = ntci_pkg::seg_at(q_item.idx);
    interp = (q_item.status == ntci_pkg::ST_OK) && (q_item.idx != ntci_pkg::FIRST_IDX)
             && seg.den_ok;
    st_nxt[0].valid  = q_valid;
    st_nxt[0].status = q_item.status;
    st_nxt[0].t_neg  = seg.dt_neg;
    st_nxt[0].r_neg  = seg.dr_neg;
    st_nxt[0].den    = interp ? seg.den : ntci_pkg::NUM_W'(1);
    st_nxt[0].rem_t  = interp ? ntci_pkg::PROD_W'(seg.dt_mag) * ntci_pkg::PROD_W'(q_item.num)
                              : '0;
    st_nxt[0].rem_r  = interp ? ntci_pkg::PROD_W'(seg.dr_mag) * ntci_pkg::PROD_W'(q_item.num)
                              : '0;
    st_nxt[0].q_t    = '0;
    st_nxt[0].q_r    = '0;
    unique case (q_item.status)
      ntci_pkg::ST_COLD: begin
        st_nxt[0].base_t = row_first.temp;
        st_nxt[0].base_r = '0;
      end
      ntci_pkg::ST_HOT: begin
        st_nxt[0].base_t = row_last.temp;
        st_nxt[0].base_r = '0;
      end
      default: begin
        st_nxt[0].base_t = cur.temp;
        st_nxt[0].base_r = cur.res;
      end
    endcase

    // divider steps, most significant quotient bit first
    for (int k = 1; k < NSTG; k++) begin
      st_nxt[k] = st_r[k-1];
      dsh   = ntci_pkg::PROD_W'(st_r[k-1].den) << (ntci_pkg::Q_W - k);
      bit_t = (st_r[k-1].rem_t >= dsh);
      bit_r = (st_r[k-1].rem_r >= dsh);
      if (bit_t) begin
        st_nxt[k].rem_t = st_r[k-1].rem_t - dsh;
      end
      if (bit_r) begin
        st_nxt[k].rem_r = st_r[k-1].rem_r - dsh;
      end
      st_nxt[k].q_t = {st_r[k-1].q_t[ntci_pkg::Q_W-2:0], bit_t};
      st_nxt[k].q_r = {st_r[k-1].q_r[ntci_pkg::Q_W-2:0], bit_r};
    end

    // apply signed quotients to the lower row
    qt_ext = $signed(ntci_pkg::TEMP_W'(st_r[NSTG-1].q_t));
    qr_ext = ntci_pkg::RES_W'(st_r[NSTG-1].q_r);
    out_temperature_nxt = st_r[NSTG-1].t_neg ? st_r[NSTG-1].base_t - qt_ext
                                             : st_r[NSTG-1].base_t + qt_ext;
    out_resistance_nxt  = st_r[NSTG-1].r_neg ? st_r[NSTG-1].base_r - qr_ext
                                             : st_r[NSTG-1].base_r + qr_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) begin
        st_r[k].valid <= 1'b0;
      end
      out_strobe_r <= 1'b0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        st_r[k] <= st_nxt[k];
      end
      out_strobe_r <= st_r[NSTG-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_temperature_r <= out_temperature_nxt;
    out_resistance_r  <= out_resistance_nxt;
    out_status_r      <= st_r[NSTG-1].status;
  end

  assign out_strobe      = out_strobe_r;
  assign out_temperature = out_temperature_r;
  assign out_resistance  = out_resistance_r;
  assign out_status      = out_status_r;

endmodule

>>> sv/ntc_table_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_table_interpolator_core
// Thermistor voltage to temperature and resistance by piecewise linear
// interpolation over a fixed table.
// ----------------------------------------------------------------------------
// path: a taken sample passes the front register, the queue, the lookup and multiply
// stage, the divider stages and the result register, then out_strobe rises
// throughput: one sample per cycle, the one-bit-per-stage divider is pipelined
// busy stays low in operation since the result side never stalls
// reset: synchronous active-low rst_n empties the front, queue and pipeline
module ntc_table_interpolator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [ntci_pkg::VOLT_W-1:0]        in_sense_voltage,
  output logic                               out_strobe,
  output logic signed [ntci_pkg::TEMP_W-1:0] out_temperature,
  output logic [ntci_pkg::RES_W-1:0]         out_resistance,
  output logic [1:0]                         out_status
);

  logic            push;
  ntci_pkg::item_t push_item;
  logic            full;
  logic            q_valid;
  ntci_pkg::item_t q_item;

  ntci_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_sense_voltage (in_sense_voltage),
    .busy             (busy),
    .push             (push),
    .push_item        (push_item),
    .full             (full)
  );

  ntci_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  ntci_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .out_strobe      (out_strobe),
    .out_temperature (out_temperature),
    .out_resistance  (out_resistance),
    .out_status      (out_status)
  );

endmodule

>>> sv/ntci_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntci_checker
// Port-level checks on latency and on the result values of each status.
// ----------------------------------------------------------------------------
module ntci_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_strobe,
  input logic signed [ntci_pkg::TEMP_W-1:0] out_temperature,
  input logic [ntci_pkg::RES_W-1:0]         out_resistance,
  input logic [1:0]                         out_status
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##20 out_strobe)
    else $error("accepted sample produced no result on time");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 20))
    else $error("result without a matching transfer");

  a_cold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ntci_pkg::ST_COLD) |->
      (out_temperature == -19'sd20000 && out_resistance == '0))
    else $error("too-cold result values wrong");

  a_hot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ntci_pkg::ST_HOT) |->
      (out_temperature == 19'sd150000 && out_resistance == '0))
    else $error("too-hot result values wrong");

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ntci_pkg::ST_OK) |->
      (out_temperature >= -19'sd20000 && out_temperature <= 19'sd150000 &&
       out_resistance >= 17'd177 && out_resistance <= 17'd87430))
    else $error("in-range result outside table span");

endmodule

bind ntc_table_interpolator_core ntci_checker u_ntci_checker (.*);

>>> dv/ntc_table_interpolator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_table_interpolator_core_test
// Drives thermistor voltages into the interpolator and checks each result
// (temperature, resistance, status) against a predictor of the fixed table
// lookup. Covers the table edges, every row point and a long random stream
// with random start gaps and a gap-free stretch.
// ----------------------------------------------------------------------------
module ntc_table_interpolator_core_test;

  localparam int ROWS        = 19;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 30;

  typedef struct packed {
    logic signed [ntci_pkg::TEMP_W-1:0] temperature;
    logic [ntci_pkg::RES_W-1:0]         resistance;
    ntci_pkg::status_t                  status;
  } reading_t;

  logic                               clk;
  logic                               rst_n;
  logic                               start;
  logic                               busy;
  logic [ntci_pkg::VOLT_W-1:0]        in_sense_voltage;
  logic                               out_strobe;
  logic signed [ntci_pkg::TEMP_W-1:0] out_temperature;
  logic [ntci_pkg::RES_W-1:0]         out_resistance;
  logic [1:0]                         out_status;

  int row_temp [0:ROWS-1] = '{-20000, -10000, 0, 5000, 10000, 15000, 20000, 25000,
                              30000, 35000, 40000, 50000, 60000, 70000, 80000,
                              90000, 100000, 120000, 150000};
  int row_res  [0:ROWS-1] = '{87430, 51820, 31770, 24940, 19680, 15620, 12470,
                              10000, 8064, 6538, 5327, 3592, 2472, 1735, 1243,
                              908, 674, 384, 177};
  int row_volt [0:ROWS-1] = '{22628, 21476, 20131, 19398, 18662, 17946, 17266,
                              16633, 16060, 15548, 15099, 14374, 13847, 13471,
                              13205, 13017, 12882, 12710, 12584};

  reading_t pending_readings[$];
  int       failures    = 0;
  int       cycle_count = 0;
  bit       no_gaps     = 0;

  ntc_table_interpolator_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_sense_voltage (in_sense_voltage),
    .out_strobe       (out_strobe),
    .out_temperature  (out_temperature),
    .out_resistance   (out_resistance),
    .out_status       (out_status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic reading_t predict_reading(input logic [ntci_pkg::VOLT_W-1:0] voltage);
    reading_t r;
    longint   v;
    longint   num;
    longint   den;
    int       seg;
    v   = longint'(voltage);
    seg = ROWS - 1;
    if (v > row_volt[0]) begin
      r.temperature = ntci_pkg::TEMP_W'(row_temp[0]);
      r.resistance  = '0;
      r.status      = ntci_pkg::ST_COLD;
    end else if (v < row_volt[ROWS-1]) begin
      r.temperature = ntci_pkg::TEMP_W'(row_temp[ROWS-1]);
      r.resistance  = '0;
      r.status      = ntci_pkg::ST_HOT;
    end else begin
      for (int i = ROWS - 1; i >= 0; i--) begin
        if (row_volt[i] <= v) seg = i;
      end
      r.status = ntci_pkg::ST_OK;
      if (seg == 0) begin
        r.temperature = ntci_pkg::TEMP_W'(row_temp[0]);
        r.resistance  = ntci_pkg::RES_W'(row_res[0]);
      end else begin
        den = longint'(row_volt[seg-1]) - row_volt[seg];
        num = v - row_volt[seg];
        if (den <= 0) begin
          r.temperature = ntci_pkg::TEMP_W'(row_temp[seg]);
          r.resistance  = ntci_pkg::RES_W'(row_res[seg]);
        end else begin
          r.temperature = ntci_pkg::TEMP_W'(row_temp[seg] +
                          (longint'(row_temp[seg-1]) - row_temp[seg]) * num / den);
          r.resistance  = ntci_pkg::RES_W'(row_res[seg] +
                          (longint'(row_res[seg-1]) - row_res[seg]) * num / den);
        end
      end
    end
    return r;
  endfunction

  task automatic start_gap();
    if (!no_gaps && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_reading(input logic [ntci_pkg::VOLT_W-1:0] voltage);
    start_gap();
    start            <= 1'b1;
    in_sense_voltage <= voltage;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_readings.push_back(predict_reading(voltage));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    reading_t exp_r;
    if (rst_n && out_strobe) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result temp %0d res %0d status %0d", $time,
                 out_temperature, out_resistance, out_status);
        failures++;
      end else begin
        exp_r = pending_readings.pop_front();
        if (out_temperature !== exp_r.temperature) begin
          $display("%0t: temperature expected %0d actual %0d", $time,
                   exp_r.temperature, out_temperature);
          failures++;
        end
        if (out_resistance !== exp_r.resistance) begin
          $display("%0t: resistance expected %0d actual %0d", $time,
                   exp_r.resistance, out_resistance);
          failures++;
        end
        if (out_status !== 2'(exp_r.status)) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_r.status, out_status);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_range_limits();
    send_reading(16'd0);
    send_reading(16'hFFFF);
    send_reading(16'(row_volt[0] + 1));
    send_reading(16'(row_volt[0]));
    send_reading(16'(row_volt[0] - 1));
    send_reading(16'(row_volt[ROWS-1]));
    send_reading(16'(row_volt[ROWS-1] - 1));
  endtask

  task automatic test_row_points();
    for (int i = 1; i < ROWS - 1; i++) send_reading(16'(row_volt[i]));
  endtask

  task automatic test_random_readings();
    logic [ntci_pkg::VOLT_W-1:0] v;
    for (int n = 0; n < 600; n++) begin
      no_gaps = (n >= 200 && n < 350);
      if ($urandom_range(0, 99) < 80)
        v = 16'($urandom_range(row_volt[ROWS-1], row_volt[0]));
      else
        v = 16'($urandom_range(0, 16'hFFFF));
      send_reading(v);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_sense_voltage = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_range_limits();
    test_row_points();
    test_random_readings();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
